// ===== hdl/eight_bit_cpu_step_unit_assert.svh =====
// Assertion macros used by the checker file of the 8-bit CPU step unit.
// Depends on nothing; included by bare file name.
`ifndef EIGHT_BIT_CPU_STEP_UNIT_ASSERT_SVH
`define EIGHT_BIT_CPU_STEP_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ECS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ecs check failed");

// next-cycle implication, disabled during reset
`define ECS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ecs check failed");

`endif

// ===== hdl/ecs_pkg.sv =====
// Shared types, codes and helpers for the 8-bit CPU step unit.
// Depends on nothing; used by every module of the block but ecs_ram.
package ecs_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // input commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // step numbers; zero marks a beat that ran no step
  localparam logic [2:0] STEP_NONE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;
  localparam logic [2:0] STEP_5    = 3'd5;
  localparam logic [2:0] STEP_6    = 3'd6;

  // opcodes (instruction bits 7..4)
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_DATA  = 4'd2;
  localparam logic [3:0] OP_JMPR  = 4'd3;
  localparam logic [3:0] OP_JMP   = 4'd4;
  localparam logic [3:0] OP_JMPC  = 4'd5;
  localparam logic [3:0] OP_CLF   = 4'd6;

  // ALU functions (low opcode bits when bit 3 is set)
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SHL = 3'd1;
  localparam logic [2:0] ALU_SHR = 3'd2;
  localparam logic [2:0] ALU_NOT = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_XOR = 3'd6;
  localparam logic [2:0] ALU_CMP = 3'd7;

  // flag bit positions
  localparam int FLAG_Z = 0;
  localparam int FLAG_E = 1;
  localparam int FLAG_A = 2;
  localparam int FLAG_C = 3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] mem_addr;
    logic [7:0] mem_wdata;
  } in_t;

  typedef struct packed {
    logic [2:0] step_done;
    logic [7:0] bus_value;
    logic [7:0] pc_value;
    logic [7:0] instr_value;
    logic [7:0] accum_value;
    logic [7:0] temp_value;
    logic [7:0] reg0_value;
    logic [7:0] reg1_value;
    logic [7:0] reg2_value;
    logic [7:0] reg3_value;
    logic [3:0] flag_bits;
    logic [7:0] read_data;
  } out_t;

  // memory request issued at accept time
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
  } mem_req_t;

  // beat held in the execute stage
  typedef struct packed {
    logic       vld;
    logic [2:0] step;
    logic       rd;
  } s1_t;

  // CPU state seen by the issue stage
  typedef struct packed {
    logic [7:0]        pc;
    logic [3:0]        op;
    logic [7:0]        gp_rb;
    logic [ADDR_W-1:0] addr_eff;
  } cpu_view_t;

  // pick one of the four general registers
  function automatic logic [7:0] gp_sel(input logic [1:0] sel, input logic [7:0] r0,
                                        input logic [7:0] r1, input logic [7:0] r2,
                                        input logic [7:0] r3);
    logic [7:0] v;
    case (sel)
      2'd0:    v = r0;
      2'd1:    v = r1;
      2'd2:    v = r2;
      default: v = r3;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/ecs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ecs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ecs_mem.sv =====
// Main memory of the CPU: RAM plus per-entry valid bits so unwritten bytes read zero.
// Depends on ecs_pkg and ecs_ram.
module ecs_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  ecs_pkg::mem_req_t req,
  output logic [7:0]       rdata
);

  logic [ecs_pkg::MEM_DEPTH-1:0] vld_r;
  logic                          vld_q_r;
  logic [7:0]                    ram_q;

  ecs_ram #(
    .WIDTH(8),
    .DEPTH(ecs_pkg::MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .re   (req.re),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  // mark written entries; clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  // sample the valid bit alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (req.re) begin
      vld_q_r <= vld_r[req.raddr];
    end
  end

  assign rdata = vld_q_r ? ram_q : 8'd0;

endmodule

// ===== hdl/ecs_exec.sv =====
// Execute stage: CPU registers, ALU and the step sequencer datapath.
// Depends on ecs_pkg; reads main memory data from ecs_mem.
module ecs_exec (
  input  logic               clk,
  input  logic               rst_n,
  input  ecs_pkg::s1_t       s1,
  input  logic               commit,
  input  logic [7:0]         rdata,
  output ecs_pkg::cpu_view_t view,
  output ecs_pkg::out_t      res
);

  logic [7:0] pc_r, instr_r, temp_r, accum_r, addr_r, bus_r;
  logic [7:0] reg0_r, reg1_r, reg2_r, reg3_r;
  logic [3:0] flag_r;

  logic [7:0] pc_nxt, instr_nxt, temp_nxt, accum_nxt, addr_nxt, bus_nxt;
  logic [7:0] reg0_nxt, reg1_nxt, reg2_nxt, reg3_nxt;
  logic [3:0] flag_nxt;

  logic [3:0] op;
  logic [1:0] ra, rb;
  logic [2:0] fn;
  logic [7:0] gpa, gpb;
  logic       cin;
  logic [8:0] sum;
  logic [7:0] alu_acc;
  logic [3:0] alu_flag;
  logic       gp_we;
  logic [1:0] gp_wsel;
  logic [7:0] gp_wdata;
  logic [2:0] step;

  assign op  = instr_r[7:4];
  assign ra  = instr_r[3:2];
  assign rb  = instr_r[1:0];
  assign fn  = op[2:0];
  assign gpa = ecs_pkg::gp_sel(ra, reg0_r, reg1_r, reg2_r, reg3_r);
  assign gpb = ecs_pkg::gp_sel(rb, reg0_r, reg1_r, reg2_r, reg3_r);
  assign cin = flag_r[ecs_pkg::FLAG_C];
  assign sum = {1'b0, gpa} + {1'b0, temp_r} + {8'd0, cin};

  // ALU: operand A is the bus (register ra), operand B is temp
  always_comb begin
    alu_acc  = accum_r;
    alu_flag = flag_r;
    case (fn)
      ecs_pkg::ALU_ADD: begin
        alu_acc                     = sum[7:0];
        alu_flag[ecs_pkg::FLAG_C]   = sum[8];
      end
      ecs_pkg::ALU_SHL: begin
        alu_acc                     = {gpa[6:0], cin};
        alu_flag[ecs_pkg::FLAG_C]   = gpa[7];
      end
      ecs_pkg::ALU_SHR: begin
        alu_acc                     = {cin, gpa[7:1]};
        alu_flag[ecs_pkg::FLAG_C]   = gpa[0];
      end
      ecs_pkg::ALU_NOT: alu_acc = ~gpa;
      ecs_pkg::ALU_AND: alu_acc = gpa & temp_r;
      ecs_pkg::ALU_OR:  alu_acc = gpa | temp_r;
      ecs_pkg::ALU_XOR: alu_acc = gpa ^ temp_r;
      default: begin
        alu_flag[ecs_pkg::FLAG_A] = gpa > temp_r;
        alu_flag[ecs_pkg::FLAG_E] = gpa == temp_r;
      end
    endcase
    alu_flag[ecs_pkg::FLAG_Z] = alu_acc == 8'd0;
  end

  // next state for the beat in this stage
  always_comb begin
    pc_nxt    = pc_r;
    instr_nxt = instr_r;
    temp_nxt  = temp_r;
    accum_nxt = accum_r;
    addr_nxt  = addr_r;
    bus_nxt   = bus_r;
    flag_nxt  = flag_r;
    gp_we     = 1'b0;
    gp_wsel   = rb;
    gp_wdata  = bus_r;
    step      = s1.vld ? s1.step : ecs_pkg::STEP_NONE;
    case (step)
      ecs_pkg::STEP_1: begin
        bus_nxt   = pc_r;
        accum_nxt = pc_r + 8'd1;
        addr_nxt  = pc_r;
      end
      ecs_pkg::STEP_2: begin
        bus_nxt   = rdata;
        instr_nxt = rdata;
      end
      ecs_pkg::STEP_3: begin
        bus_nxt = accum_r;
        pc_nxt  = accum_r;
      end
      ecs_pkg::STEP_4: begin
        if (op[3]) begin
          bus_nxt  = gpb;
          temp_nxt = gpb;
        end else if (op == ecs_pkg::OP_LOAD || op == ecs_pkg::OP_STORE ||
                     op == ecs_pkg::OP_JMPR) begin
          bus_nxt  = gpa;
          addr_nxt = gpa;
        end else if (op == ecs_pkg::OP_DATA || op == ecs_pkg::OP_JMPC) begin
          bus_nxt   = pc_r;
          accum_nxt = pc_r + 8'd1;
          addr_nxt  = pc_r;
        end else if (op == ecs_pkg::OP_JMP) begin
          bus_nxt  = pc_r;
          addr_nxt = pc_r;
        end else if (op == ecs_pkg::OP_CLF) begin
          flag_nxt = 4'd0;
        end
      end
      ecs_pkg::STEP_5: begin
        if (op[3]) begin
          accum_nxt = alu_acc;
          flag_nxt  = alu_flag;
          if (fn != ecs_pkg::ALU_CMP) begin
            bus_nxt  = alu_acc;
            gp_we    = 1'b1;
            gp_wdata = alu_acc;
          end else begin
            bus_nxt = gpa;
          end
        end else if (op == ecs_pkg::OP_LOAD) begin
          bus_nxt  = rdata;
          gp_we    = 1'b1;
          gp_wdata = rdata;
        end else if (op == ecs_pkg::OP_STORE) begin
          // memory write already issued at accept
          bus_nxt = gpb;
        end else if (op == ecs_pkg::OP_DATA) begin
          bus_nxt  = rdata;
          gp_we    = 1'b1;
          gp_wsel  = ra;
          gp_wdata = rdata;
        end else if (op == ecs_pkg::OP_JMPR) begin
          bus_nxt = gpa;
          pc_nxt  = gpa;
        end else if (op == ecs_pkg::OP_JMP) begin
          bus_nxt = rdata;
          pc_nxt  = rdata;
        end else if (op == ecs_pkg::OP_JMPC) begin
          bus_nxt = accum_r;
          pc_nxt  = accum_r;
        end
      end
      ecs_pkg::STEP_6: begin
        if (op[3]) begin
          if (fn != ecs_pkg::ALU_CMP) begin
            bus_nxt  = accum_r;
            gp_we    = 1'b1;
            gp_wdata = accum_r;
          end
        end else if (op == ecs_pkg::OP_DATA) begin
          bus_nxt = accum_r;
          pc_nxt  = accum_r;
        end else if (op == ecs_pkg::OP_JMPC) begin
          if ((flag_r & instr_r[3:0]) != 4'd0) begin
            bus_nxt = rdata;
            pc_nxt  = rdata;
          end
        end
      end
      default: begin
      end
    endcase
    reg0_nxt = (gp_we && gp_wsel == 2'd0) ? gp_wdata : reg0_r;
    reg1_nxt = (gp_we && gp_wsel == 2'd1) ? gp_wdata : reg1_r;
    reg2_nxt = (gp_we && gp_wsel == 2'd2) ? gp_wdata : reg2_r;
    reg3_nxt = (gp_we && gp_wsel == 2'd3) ? gp_wdata : reg3_r;
  end

  // advance architectural state when the beat leaves this stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      instr_r <= '0;
      temp_r  <= '0;
      accum_r <= '0;
      addr_r  <= '0;
      bus_r   <= '0;
      flag_r  <= '0;
      reg0_r  <= '0;
      reg1_r  <= '0;
      reg2_r  <= '0;
      reg3_r  <= '0;
    end else if (commit) begin
      pc_r    <= pc_nxt;
      instr_r <= instr_nxt;
      temp_r  <= temp_nxt;
      accum_r <= accum_nxt;
      addr_r  <= addr_nxt;
      bus_r   <= bus_nxt;
      flag_r  <= flag_nxt;
      reg0_r  <= reg0_nxt;
      reg1_r  <= reg1_nxt;
      reg2_r  <= reg2_nxt;
      reg3_r  <= reg3_nxt;
    end
  end

  // state for the issue stage; the address register is forwarded from here
  assign view.pc       = pc_r;
  assign view.op       = op;
  assign view.gp_rb    = gpb;
  assign view.addr_eff = addr_nxt[ecs_pkg::ADDR_W-1:0];

  // result beat built from the next state
  assign res.step_done   = step;
  assign res.bus_value   = bus_nxt;
  assign res.pc_value    = pc_nxt;
  assign res.instr_value = instr_nxt;
  assign res.accum_value = accum_nxt;
  assign res.temp_value  = temp_nxt;
  assign res.reg0_value  = reg0_nxt;
  assign res.reg1_value  = reg1_nxt;
  assign res.reg2_value  = reg2_nxt;
  assign res.reg3_value  = reg3_nxt;
  assign res.flag_bits   = flag_nxt;
  assign res.read_data   = (s1.vld && s1.rd) ? rdata : 8'd0;

endmodule

// ===== hdl/eight_bit_cpu_step_unit.sv =====
// 8-bit CPU step unit: one beat per command, one result beat per command.
// An accepted beat is registered with its memory read, then executed into the output register.
// Throughput: 1 beat per cycle while out_ready is high; a stalled output register holds
// the beat in the execute stage, and out_ready reaches in_ready combinationally.
// Reset (rst_n low, synchronous): CPU registers zero, step counter one, memory
// reads zero via per-entry valid bits until written, no clearing pass.
module eight_bit_cpu_step_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ecs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ecs_pkg::out_t  out_data
);

  logic               accept;
  logic               s1_move;
  logic               is_step;
  logic [2:0]         step_r;
  logic [2:0]         step_cur;
  logic [2:0]         step_nxt;
  ecs_pkg::s1_t       s1_r;
  ecs_pkg::mem_req_t  req;
  ecs_pkg::cpu_view_t view;
  ecs_pkg::out_t      res;
  ecs_pkg::out_t      out_r;
  logic               out_v_r;
  logic [7:0]         rdata;

  // handshake: take a beat whenever the execute stage is empty or empties this cycle
  assign s1_move  = s1_r.vld && (!out_v_r || out_ready);
  assign in_ready = !s1_r.vld || s1_move;
  assign accept   = in_valid && in_ready;
  assign is_step  = in_data.cmd == ecs_pkg::CMD_STEP;

  // step counter lives in the issue stage
  always_comb begin
    step_cur = step_r;
    if (step_r == ecs_pkg::STEP_NONE || step_r > ecs_pkg::STEP_6) begin
      step_cur = ecs_pkg::STEP_1;
    end
    step_nxt = (step_cur == ecs_pkg::STEP_6) ? ecs_pkg::STEP_1 : step_cur + 3'd1;
  end

  // memory request; the prior beat cannot change pc, instr or registers used here
  always_comb begin
    req.re    = accept;
    req.raddr = view.addr_eff;
    if (in_data.cmd == ecs_pkg::CMD_READ) begin
      req.raddr = in_data.mem_addr;
    end else if (step_cur == ecs_pkg::STEP_2) begin
      req.raddr = view.pc;
    end
    req.we    = 1'b0;
    req.waddr = view.addr_eff;
    req.wdata = view.gp_rb;
    if (accept && in_data.cmd == ecs_pkg::CMD_WRITE) begin
      req.we    = 1'b1;
      req.waddr = in_data.mem_addr;
      req.wdata = in_data.mem_wdata;
    end else if (accept && is_step && step_cur == ecs_pkg::STEP_5 &&
                 view.op == ecs_pkg::OP_STORE) begin
      req.we = 1'b1;
    end
  end

  // issue stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ecs_pkg::STEP_1;
      s1_r   <= '0;
    end else begin
      if (accept) begin
        s1_r.vld  <= 1'b1;
        s1_r.step <= is_step ? step_cur : ecs_pkg::STEP_NONE;
        s1_r.rd   <= in_data.cmd == ecs_pkg::CMD_READ;
        if (is_step) begin
          step_r <= step_nxt;
        end
      end else if (s1_move) begin
        s1_r.vld <= 1'b0;
      end
    end
  end

  ecs_mem u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rdata(rdata)
  );

  ecs_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1_r),
    .commit(s1_move),
    .rdata (rdata),
    .view  (view),
    .res   (res)
  );

  // output register: hold while stalled, load as the execute beat retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/ecs_checker.sv =====
// Port-level checker for the 8-bit CPU step unit, bound to the top level.
// Depends on ecs_pkg and eight_bit_cpu_step_unit_assert.svh.
`include "eight_bit_cpu_step_unit_assert.svh"

module ecs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input ecs_pkg::out_t out_data,
  input logic          out_valid,
  input logic          out_ready
);

  // a stalled result beat stays and holds its payload
  `ECS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ECS_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

  // read data shows only on beats that ran no step
  `ECS_ASSERT_NOW(a_rd_no_step, clk, rst_n,
                  out_valid && out_data.step_done != ecs_pkg::STEP_NONE,
                  out_data.read_data == 8'd0)

  // out_valid follows a beat accepted while the output is empty, through the issue and output registers
  `ECS_ASSERT_NOW(a_latency, clk, rst_n,
                  in_valid && in_ready && !out_valid, ##2 out_valid)

endmodule

bind eight_bit_cpu_step_unit ecs_checker u_ecs_checker (.*);

// ===== test/cpu_state_tracker_pkg.sv =====
// State tracker for the 8-bit CPU step unit testbench: mirrors memory, registers
// and step counter, and checks the visible-state beats the unit returns.
// Depends on ecs_pkg for the beat types, command, opcode and flag codes.
package cpu_state_tracker_pkg;
  import ecs_pkg::*;

  class cpu_state_tracker;
    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] gp [4];
    logic [7:0] pc;
    logic [7:0] ir;
    logic [7:0] tmp;
    logic [7:0] acc;
    logic [7:0] mar;
    logic [7:0] bus;
    logic [3:0] flags;
    logic [2:0] step;

    out_t pending_states[$];
    int   mismatch_cnt;
    int   checked_cnt;

    function new();
      reset_state();
      mismatch_cnt = 0;
      checked_cnt  = 0;
    endfunction

    function void reset_state();
      foreach (mem[i]) mem[i] = 8'h00;
      foreach (gp[i]) gp[i] = 8'h00;
      pc    = 8'h00;
      ir    = 8'h00;
      tmp   = 8'h00;
      acc   = 8'h00;
      mar   = 8'h00;
      bus   = 8'h00;
      flags = 4'h0;
      step  = STEP_1;
    endfunction

    // put pc on the bus and pc+1 in the accumulator; flags untouched
    function void bump_address();
      bus = pc;
      acc = bus + 8'd1;
      mar = bus;
    endfunction

    // operand A from the bus, operand B from tmp
    function void alu_exec(logic [2:0] fn);
      logic [8:0] sum;
      logic       cin;
      logic [7:0] a;
      logic [7:0] b;
      a   = bus;
      b   = tmp;
      cin = flags[FLAG_C];
      case (fn)
        ALU_ADD: begin
          sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
          acc = sum[7:0];
          flags[FLAG_C] = sum[8];
        end
        ALU_SHL: begin
          acc = {a[6:0], cin};
          flags[FLAG_C] = a[7];
        end
        ALU_SHR: begin
          acc = {cin, a[7:1]};
          flags[FLAG_C] = a[0];
        end
        ALU_NOT: acc = ~a;
        ALU_AND: acc = a & b;
        ALU_OR:  acc = a | b;
        ALU_XOR: acc = a ^ b;
        default: begin
          flags[FLAG_A] = (a > b);
          flags[FLAG_E] = (a == b);
        end
      endcase
      flags[FLAG_Z] = (acc == 8'h00);
    endfunction

    function void exec_step(logic [2:0] s);
      logic [3:0] op;
      logic [1:0] ra;
      logic [1:0] rb;
      op = ir[7:4];
      ra = ir[3:2];
      rb = ir[1:0];
      case (s)
        STEP_1: bump_address();
        STEP_2: begin
          bus = mem[bus];
          ir  = bus;
        end
        STEP_3: begin
          bus = acc;
          pc  = bus;
        end
        STEP_4: begin
          if (op == OP_LOAD || op == OP_STORE || op == OP_JMPR) begin
            bus = gp[ra];
            mar = bus;
          end else if (op == OP_DATA || op == OP_JMPC) begin
            bump_address();
          end else if (op == OP_JMP) begin
            bus = pc;
            mar = bus;
          end else if (op == OP_CLF) begin
            flags = 4'h0;
          end else if (op[3]) begin
            bus = gp[rb];
            tmp = bus;
          end
        end
        STEP_5: begin
          if (op == OP_LOAD) begin
            bus    = mem[mar];
            gp[rb] = bus;
          end else if (op == OP_STORE) begin
            bus      = gp[rb];
            mem[mar] = bus;
          end else if (op == OP_DATA) begin
            bus    = mem[mar];
            gp[ra] = bus;
          end else if (op == OP_JMPR) begin
            bus = gp[ra];
            pc  = bus;
          end else if (op == OP_JMP) begin
            bus = mem[mar];
            pc  = bus;
          end else if (op == OP_JMPC) begin
            bus = acc;
            pc  = bus;
          end else if (op[3]) begin
            bus = gp[ra];
            alu_exec(op[2:0]);
            // compare leaves the bus and the registers alone
            if (op[2:0] != ALU_CMP) begin
              bus    = acc;
              gp[rb] = bus;
            end
          end
        end
        default: begin
          if (op == OP_DATA) begin
            bus = acc;
            pc  = bus;
          end else if (op == OP_JMPC) begin
            // take the jump only when a masked flag is set
            if ((flags & ir[3:0]) != 4'h0) begin
              bus = mem[mar];
              pc  = bus;
            end
          end else if (op[3] && op[2:0] != ALU_CMP) begin
            bus    = acc;
            gp[rb] = bus;
          end
        end
      endcase
    endfunction

    // advance the mirror by one command and return the state it exposes
    function out_t apply(in_t c);
      out_t       res;
      logic [2:0] s;
      logic [2:0] done;
      logic [7:0] rdata;
      done  = STEP_NONE;
      rdata = 8'h00;
      case (c.cmd)
        CMD_WRITE: mem[c.mem_addr] = c.mem_wdata;
        CMD_READ:  rdata = mem[c.mem_addr];
        CMD_STEP: begin
          s = step;
          if (s < STEP_1 || s > STEP_6) s = STEP_1;
          exec_step(s);
          done = s;
          step = (s == STEP_6) ? STEP_1 : s + 3'd1;
        end
        default: ;
      endcase
      res.step_done   = done;
      res.bus_value   = bus;
      res.pc_value    = pc;
      res.instr_value = ir;
      res.accum_value = acc;
      res.temp_value  = tmp;
      res.reg0_value  = gp[0];
      res.reg1_value  = gp[1];
      res.reg2_value  = gp[2];
      res.reg3_value  = gp[3];
      res.flag_bits   = flags;
      res.read_data   = rdata;
      return res;
    endfunction

    function void note_command(in_t c);
      pending_states.push_back(apply(c));
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch %s on result %0d: expected %h, got %h",
                   name, checked_cnt, want, got);
      end
    endfunction

    function void check_state(out_t got);
      out_t want;
      checked_cnt++;
      if (pending_states.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result %0d with nothing pending", checked_cnt);
        return;
      end
      want = pending_states.pop_front();
      cmp_field("step_done", {5'd0, want.step_done}, {5'd0, got.step_done});
      cmp_field("bus_value", want.bus_value, got.bus_value);
      cmp_field("pc_value", want.pc_value, got.pc_value);
      cmp_field("instr_value", want.instr_value, got.instr_value);
      cmp_field("accum_value", want.accum_value, got.accum_value);
      cmp_field("temp_value", want.temp_value, got.temp_value);
      cmp_field("reg0_value", want.reg0_value, got.reg0_value);
      cmp_field("reg1_value", want.reg1_value, got.reg1_value);
      cmp_field("reg2_value", want.reg2_value, got.reg2_value);
      cmp_field("reg3_value", want.reg3_value, got.reg3_value);
      cmp_field("flag_bits", {4'd0, want.flag_bits}, {4'd0, got.flag_bits});
      cmp_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

endpackage

// ===== test/eight_bit_cpu_step_unit_test.sv =====
// Testbench for eight_bit_cpu_step_unit: random programs and memory traffic with
// random idling on both channels. Depends on ecs_pkg and cpu_state_tracker_pkg.
module eight_bit_cpu_step_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ecs_pkg::*;
  import cpu_state_tracker_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [3:0] OP_UNUSED  = 4'd7;
  localparam int         TARGET_CMDS = 1100;
  localparam int         HOLD_CYCLES = 80;
  localparam int         HOLD_AFTER  = 300;
  localparam int         DRAIN_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  cpu_state_tracker tracker = new();
  cpu_state_tracker plan = new();
  int  sent_cnt = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  hold_done = 1'b0;

  eight_bit_cpu_step_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one beat, hold it until accepted, then idle for a random gap, possibly none
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] addr,
                          input logic [7:0] wdata);
    in_t beat;
    int  gap;
    beat.cmd       = cmd;
    beat.mem_addr  = addr;
    beat.mem_wdata = wdata;
    void'(plan.apply(beat));
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic step_cpu(input int n);
    repeat (n) send_cmd(CMD_STEP, 8'($urandom), 8'($urandom));
  endtask

  // place a random instruction at pc, its operand behind it if it takes one, and run it
  task automatic run_instruction();
    logic [7:0] p;
    logic [7:0] instr;
    while (plan.step != STEP_1) step_cpu(1);
    p     = plan.pc;
    instr = 8'($urandom);
    send_cmd(CMD_WRITE, p, instr);
    if (instr[7:4] == OP_DATA || instr[7:4] == OP_JMP || instr[7:4] == OP_JMPC)
      send_cmd(CMD_WRITE, p + 8'd1, 8'($urandom));
    step_cpu(6);
  endtask

  // stray memory traffic, unused command and broken step runs
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_cmd(CMD_WRITE, 8'($urandom), 8'($urandom));
      1: send_cmd(CMD_READ, 8'($urandom), 8'($urandom));
      2: send_cmd(CMD_UNUSED, 8'($urandom), 8'($urandom));
      default: step_cpu($urandom_range(1, 5));
    endcase
  endtask

  // check every accepted beat on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_command(in_data);
      if (out_valid && out_ready) tracker.check_state(out_data);
    end
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && tracker.checked_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 2) recv_calm = !recv_calm;
      n = pick_gap(recv_calm);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int i;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, unwritten reads, unused command
    send_cmd(CMD_WRITE, 8'hFF, 8'hFF);
    send_cmd(CMD_READ, 8'hFF, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'hFF);
    send_cmd(CMD_READ, 8'h80, 8'h00);
    send_cmd(CMD_UNUSED, 8'hAA, 8'h55);
    // load 0xFF into r0, add r0 to itself, then an unused opcode
    send_cmd(CMD_WRITE, 8'h00, {OP_DATA, 2'd0, 2'd0});
    send_cmd(CMD_WRITE, 8'h01, 8'hFF);
    send_cmd(CMD_WRITE, 8'h02, {1'b1, ALU_ADD, 2'd0, 2'd0});
    send_cmd(CMD_WRITE, 8'h03, {OP_UNUSED, 4'hF});
    step_cpu(18);
    send_cmd(CMD_READ, 8'h03, 8'h00);

    // random programs with some noise mixed in
    while (sent_cnt < TARGET_CMDS) begin
      if ($urandom_range(0, 99) < 80) run_instruction();
      else send_noise();
    end
    in_valid <= 1'b0;

    // drain until every accepted beat has come back
    for (i = 0; i < DRAIN_LIMIT && tracker.checked_cnt < sent_cnt; i++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.pending_states.size() != 0) begin
      tracker.mismatch_cnt++;
      $display("%0d results never arrived", tracker.pending_states.size());
    end
    if (tracker.mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ecs_pkg.sv
hdl/ecs_ram.sv
hdl/ecs_mem.sv
hdl/ecs_exec.sv
hdl/eight_bit_cpu_step_unit.sv
hdl/ecs_checker.sv
test/cpu_state_tracker_pkg.sv
test/eight_bit_cpu_step_unit_test.sv
